// ----- hdl/staggered_grid_trilinear_weights_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the staggered-grid trilinear weights unit
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef STAGGERED_GRID_TRILINEAR_WEIGHTS_UNIT_ASSERT_SVH
`define STAGGERED_GRID_TRILINEAR_WEIGHTS_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define SGTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds -> cons holds in the next cycle
`define SGTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sgtw_pkg.sv -----
// ----------------------------------------------------------------------------
// sgtw_pkg
// Shared constants and types for the staggered-grid trilinear weights unit.
// ----------------------------------------------------------------------------
package sgtw_pkg;

   // default grid size in cells along each axis
   localparam int GRID_X_DEF = 64;
   localparam int GRID_Y_DEF = 64;
   localparam int GRID_Z_DEF = 64;

   // field widths
   localparam int POS_W        = 32;
   localparam int DIFF_W       = 33;
   localparam int PPROD_W      = 50;
   localparam int SCALED_W     = 49;
   localparam int IDX_W        = 33;
   localparam int FRAC_W       = 17;
   localparam int WPROD_W      = 49;
   localparam int NODE_INDEX_W = 19;
   localparam int CORNER_W     = 3;

   typedef logic [1:0] axis_type;
   typedef logic [2:0] csr_index_type;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam csr_index_type CSR_FACE_AXIS = 3'd0;
   localparam csr_index_type CSR_SCALE_X   = 3'd1;
   localparam csr_index_type CSR_SCALE_Y   = 3'd2;
   localparam csr_index_type CSR_SCALE_Z   = 3'd3;
   localparam csr_index_type CSR_ORIGIN_X  = 3'd4;
   localparam csr_index_type CSR_ORIGIN_Y  = 3'd5;
   localparam csr_index_type CSR_ORIGIN_Z  = 3'd6;

   localparam logic [31:0]          SCALE_RESET = 32'h0001_0000;
   localparam logic [FRAC_W-1:0]    ONE_Q16     = 17'h1_0000;
   localparam logic [SCALED_W-1:0]  HALF_Q16    = 49'h8000;
   localparam logic [WPROD_W-1:0]   ROUND_HALF  = 49'h0_8000_0000;
   localparam logic [CORNER_W-1:0]  LAST_CORNER = 3'd7;

endpackage

// ----- hdl/staggered_grid_trilinear_weights_unit.sv -----
// ----------------------------------------------------------------------------
// Staggered-grid trilinear weights unit
// Turns one particle position into the eight node indices and trilinear
// weights of its surrounding cell on a face-staggered grid.
// ----------------------------------------------------------------------------
// A particle is taken when start is high and busy is low. Its eight corner
// results follow on the rsp_ ports, one per cycle in corner order 0..7,
// each marked by a one-cycle rsp_valid strobe; the receiver cannot stall
// them. The first result passes the front stages, the corner sequencer,
// the c1 and c2 registers and the output register. The result port carries
// one corner per cycle, so successive particles' corners can leave back
// to back; the six-stage front pipeline buffers particles that arrive faster
// and raises busy once it is full. Configuration writes are always taken
// (csr_ready stays high) and must only happen while no particle is in flight.
`include "staggered_grid_trilinear_weights_unit_assert.svh"

module staggered_grid_trilinear_weights_unit #(
   parameter int GRID_X = sgtw_pkg::GRID_X_DEF,
   parameter int GRID_Y = sgtw_pkg::GRID_Y_DEF,
   parameter int GRID_Z = sgtw_pkg::GRID_Z_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // particle input
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [sgtw_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [sgtw_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [sgtw_pkg::POS_W-1:0]      req_pos_z,
   // corner results
   output logic                                   rsp_valid,
   output logic [sgtw_pkg::NODE_INDEX_W-1:0]      rsp_node_index,
   output logic [sgtw_pkg::FRAC_W-1:0]            rsp_weight,
   output logic [sgtw_pkg::CORNER_W-1:0]          rsp_corner_number,
   output logic                                   rsp_out_of_range,
   output logic                                   rsp_last_of_particle,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  sgtw_pkg::csr_index_type                csr_index,
   input  logic [31:0]                            csr_data
);

   localparam int TOTAL_MAX = (GRID_X + 1) * (GRID_Y + 1) * (GRID_Z + 1);
   localparam int STR_W     = $clog2(TOTAL_MAX + 1);
   localparam int PROD_W    = sgtw_pkg::IDX_W + STR_W + 1;
   localparam int BASE_W    = PROD_W + 2;
   localparam int NSTG      = 6;

   localparam int S0_FA0  = GRID_Y * GRID_Z;
   localparam int S0_FA1  = (GRID_Y + 1) * GRID_Z;
   localparam int S0_FA2  = GRID_Y * (GRID_Z + 1);
   localparam int S1_FA0  = GRID_Z;
   localparam int S1_FA1  = GRID_Z;
   localparam int S1_FA2  = GRID_Z + 1;
   localparam int TOT_FA0 = (GRID_X + 1) * GRID_Y * GRID_Z;
   localparam int TOT_FA1 = GRID_X * (GRID_Y + 1) * GRID_Z;
   localparam int TOT_FA2 = GRID_X * GRID_Y * (GRID_Z + 1);

   localparam logic signed [sgtw_pkg::IDX_W-1:0] LIM_A [3] = '{
      sgtw_pkg::IDX_W'(GRID_X - 2),
      sgtw_pkg::IDX_W'(GRID_Y - 2),
      sgtw_pkg::IDX_W'(GRID_Z - 2)
   };

   // configuration registers
   sgtw_pkg::axis_type             face_axis_ff;
   logic [31:0]                    scale_ff  [3];
   logic [31:0]                    origin_ff [3];

   // decoded face axis and grid geometry
   logic [2:0]                     face_sel;
   logic [STR_W-1:0]               stride0;
   logic [STR_W-1:0]               stride1;
   logic [STR_W-1:0]               total_sel;

   // front pipeline control
   logic [NSTG-1:0]                stg_vld_ff;
   logic [NSTG-1:0]                stg_vld_in;
   logic [NSTG-1:0]                adv;
   logic                           accept;
   logic                           ser_load;

   // front pipeline data
   logic signed [sgtw_pkg::DIFF_W-1:0]   t_ff    [3];
   logic signed [sgtw_pkg::DIFF_W-1:0]   t_in    [3];
   logic signed [sgtw_pkg::PPROD_W-1:0]  plo_ff  [3];
   logic signed [sgtw_pkg::PPROD_W-1:0]  plo_in  [3];
   logic signed [sgtw_pkg::PPROD_W-1:0]  phi_ff  [3];
   logic signed [sgtw_pkg::PPROD_W-1:0]  phi_in  [3];
   logic signed [sgtw_pkg::SCALED_W-1:0] s_ff    [3];
   logic signed [sgtw_pkg::SCALED_W-1:0] s_in    [3];
   logic signed [sgtw_pkg::IDX_W-1:0]    idx_ff  [3];
   logic signed [sgtw_pkg::IDX_W-1:0]    idx_in  [3];
   logic [sgtw_pkg::FRAC_W-1:0]          frac3_ff [3];
   logic [sgtw_pkg::FRAC_W-1:0]          frac3_in [3];
   logic signed [PROD_W-1:0]             prod0_ff;
   logic signed [PROD_W-1:0]             prod0_in;
   logic signed [PROD_W-1:0]             prod1_ff;
   logic signed [PROD_W-1:0]             prod1_in;
   logic signed [sgtw_pkg::IDX_W-1:0]    idx2_ff;
   logic [sgtw_pkg::FRAC_W-1:0]          frac4_ff [3];
   logic signed [BASE_W-1:0]             base_ff;
   logic signed [BASE_W-1:0]             base_in;
   logic [sgtw_pkg::FRAC_W-1:0]          frac5_ff [3];

   // corner sequencer
   logic                                 ser_vld_ff;
   logic                                 ser_vld_in;
   logic [sgtw_pkg::CORNER_W-1:0]        ser_cnt_ff;
   logic [sgtw_pkg::CORNER_W-1:0]        ser_cnt_in;
   logic signed [BASE_W-1:0]             ser_base_ff;
   logic [sgtw_pkg::FRAC_W-1:0]          ser_frac_ff [3];

   // corner pipeline
   logic                                 c1_vld_ff;
   logic signed [BASE_W-1:0]             c1_node_ff;
   logic signed [BASE_W-1:0]             c1_node_in;
   logic [2*sgtw_pkg::FRAC_W-1:0]        c1_w_ff;
   logic [2*sgtw_pkg::FRAC_W-1:0]        c1_w_in;
   logic [sgtw_pkg::FRAC_W-1:0]          c1_f2_ff;
   logic [sgtw_pkg::FRAC_W-1:0]          c1_f2_in;
   logic [sgtw_pkg::CORNER_W-1:0]        c1_corner_ff;
   logic [STR_W:0]                       c1_off;
   logic [sgtw_pkg::FRAC_W-1:0]          c1_f0;
   logic [sgtw_pkg::FRAC_W-1:0]          c1_f1;

   logic                                 c2_vld_ff;
   logic [sgtw_pkg::NODE_INDEX_W-1:0]    c2_idx_ff;
   logic [sgtw_pkg::NODE_INDEX_W-1:0]    c2_idx_in;
   logic                                 c2_oor_ff;
   logic                                 c2_oor_in;
   logic [sgtw_pkg::WPROD_W-1:0]         c2_w_ff;
   logic [sgtw_pkg::WPROD_W-1:0]         c2_w_in;
   logic [sgtw_pkg::CORNER_W-1:0]        c2_corner_ff;

   logic [sgtw_pkg::WPROD_W-1:0]         w_round;

   // output registers
   logic                                 rsp_valid_ff;
   logic [sgtw_pkg::NODE_INDEX_W-1:0]    rsp_node_index_ff;
   logic [sgtw_pkg::FRAC_W-1:0]          rsp_weight_ff;
   logic [sgtw_pkg::CORNER_W-1:0]        rsp_corner_ff;
   logic                                 rsp_oor_ff;
   logic                                 rsp_last_ff;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_axis_ff <= sgtw_pkg::AXIS_X;
         for (int a = 0; a < 3; a++) begin
            scale_ff[a]  <= sgtw_pkg::SCALE_RESET;
            origin_ff[a] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sgtw_pkg::CSR_FACE_AXIS: face_axis_ff <= csr_data[1:0];
            sgtw_pkg::CSR_SCALE_X:   scale_ff[0]  <= csr_data;
            sgtw_pkg::CSR_SCALE_Y:   scale_ff[1]  <= csr_data;
            sgtw_pkg::CSR_SCALE_Z:   scale_ff[2]  <= csr_data;
            sgtw_pkg::CSR_ORIGIN_X:  origin_ff[0] <= csr_data;
            sgtw_pkg::CSR_ORIGIN_Y:  origin_ff[1] <= csr_data;
            sgtw_pkg::CSR_ORIGIN_Z:  origin_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // unused selector code falls back to z
   always_comb begin
      case (face_axis_ff)
         sgtw_pkg::AXIS_X: begin
            face_sel  = 3'b001;
            stride0   = STR_W'(S0_FA0);
            stride1   = STR_W'(S1_FA0);
            total_sel = STR_W'(TOT_FA0);
         end
         sgtw_pkg::AXIS_Y: begin
            face_sel  = 3'b010;
            stride0   = STR_W'(S0_FA1);
            stride1   = STR_W'(S1_FA1);
            total_sel = STR_W'(TOT_FA1);
         end
         default: begin
            face_sel  = 3'b100;
            stride0   = STR_W'(S0_FA2);
            stride1   = STR_W'(S1_FA2);
            total_sel = STR_W'(TOT_FA2);
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Front pipeline flow control
   // ------------------------------------------------------------------
   assign ser_load = stg_vld_ff[NSTG-1] &
                     (~ser_vld_ff | (ser_cnt_ff == sgtw_pkg::LAST_CORNER));

   always_comb begin
      adv[NSTG-1] = ser_load;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = stg_vld_ff[k] & (~stg_vld_ff[k+1] | adv[k+1]);
      end
   end

   // hold the input off while in reset
   assign busy   = reset | (stg_vld_ff[0] & ~adv[0]);
   assign accept = start & ~busy;

   always_comb begin
      stg_vld_in[0] = accept | (stg_vld_ff[0] & ~adv[0]);
      for (int k = 1; k < NSTG; k++) begin
         stg_vld_in[k] = adv[k-1] | (stg_vld_ff[k] & ~adv[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   // ------------------------------------------------------------------
   // Front pipeline datapath
   // ------------------------------------------------------------------
   // stage 0: offset from the grid corner
   always_comb begin
      t_in[0] = $signed({req_pos_x[31], req_pos_x}) -
                $signed({origin_ff[0][31], origin_ff[0]});
      t_in[1] = $signed({req_pos_y[31], req_pos_y}) -
                $signed({origin_ff[1][31], origin_ff[1]});
      t_in[2] = $signed({req_pos_z[31], req_pos_z}) -
                $signed({origin_ff[2][31], origin_ff[2]});
   end

   // stage 1: scale multiply split into two 16-bit halves of the scale
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         plo_in[a] = t_ff[a] * $signed({1'b0, scale_ff[a][15:0]});
         phi_in[a] = t_ff[a] * $signed({1'b0, scale_ff[a][31:16]});
      end
   end

   // stage 2: recombine halves and drop 16 fraction bits (floor)
   always_comb begin
      logic [2*sgtw_pkg::DIFF_W-1:0] full;
      full = '0;
      for (int a = 0; a < 3; a++) begin
         full = {phi_ff[a], 16'h0000} + {{16{plo_ff[a][sgtw_pkg::PPROD_W-1]}}, plo_ff[a]};
         s_in[a] = $signed(full[sgtw_pkg::SCALED_W+15:16]);
      end
   end

   // stage 3: cell index and fraction, centred axes shifted by half a cell and clamped
   always_comb begin
      logic signed [sgtw_pkg::SCALED_W-1:0] cs;
      logic signed [sgtw_pkg::IDX_W-1:0]    ci;
      cs = '0;
      ci = '0;
      for (int a = 0; a < 3; a++) begin
         if (face_sel[a]) begin
            idx_in[a]   = s_ff[a][sgtw_pkg::SCALED_W-1:16];
            frac3_in[a] = {1'b0, s_ff[a][15:0]};
         end else begin
            cs = s_ff[a] - $signed(sgtw_pkg::HALF_Q16);
            ci = cs[sgtw_pkg::SCALED_W-1:16];
            if (ci[sgtw_pkg::IDX_W-1]) begin
               idx_in[a]   = '0;
               frac3_in[a] = '0;
            end else if (ci > LIM_A[a]) begin
               idx_in[a]   = LIM_A[a];
               frac3_in[a] = sgtw_pkg::ONE_Q16;
            end else begin
               idx_in[a]   = ci;
               frac3_in[a] = {1'b0, cs[15:0]};
            end
         end
      end
   end

   // stage 4: index times stride
   assign prod0_in = idx_ff[0] * $signed({1'b0, stride0});
   assign prod1_in = idx_ff[1] * $signed({1'b0, stride1});

   // stage 5: flattened base index
   assign base_in = BASE_W'(prod0_ff) + BASE_W'(prod1_ff) + BASE_W'(idx2_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff <= t_in;
      end
      if (adv[0]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (adv[1]) begin
         s_ff <= s_in;
      end
      if (adv[2]) begin
         idx_ff   <= idx_in;
         frac3_ff <= frac3_in;
      end
      if (adv[3]) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         idx2_ff  <= idx_ff[2];
         frac4_ff <= frac3_ff;
      end
      if (adv[4]) begin
         base_ff  <= base_in;
         frac5_ff <= frac4_ff;
      end
      if (ser_load) begin
         ser_base_ff <= base_ff;
         ser_frac_ff <= frac5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Corner sequencer: one corner a cycle, next particle on the last one
   // ------------------------------------------------------------------
   always_comb begin
      ser_vld_in = ser_vld_ff;
      ser_cnt_in = ser_cnt_ff;
      if (ser_load) begin
         ser_vld_in = 1'b1;
         ser_cnt_in = '0;
      end else if (ser_vld_ff) begin
         if (ser_cnt_ff == sgtw_pkg::LAST_CORNER) begin
            ser_vld_in = 1'b0;
         end else begin
            ser_cnt_in = ser_cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         ser_cnt_ff <= '0;
      end else begin
         ser_vld_ff <= ser_vld_in;
         ser_cnt_ff <= ser_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Corner pipeline
   // ------------------------------------------------------------------
   always_comb begin
      c1_off = (ser_cnt_ff[0] ? {1'b0, stride0} : '0) +
               (ser_cnt_ff[1] ? {1'b0, stride1} : '0) +
               (STR_W + 1)'(ser_cnt_ff[2]);
      c1_node_in = ser_base_ff + $signed(BASE_W'(c1_off));
      c1_f0 = ser_cnt_ff[0] ? ser_frac_ff[0] : sgtw_pkg::ONE_Q16 - ser_frac_ff[0];
      c1_f1 = ser_cnt_ff[1] ? ser_frac_ff[1] : sgtw_pkg::ONE_Q16 - ser_frac_ff[1];
      c1_f2_in = ser_cnt_ff[2] ? ser_frac_ff[2] : sgtw_pkg::ONE_Q16 - ser_frac_ff[2];
      c1_w_in = c1_f0 * c1_f1;
   end

   // saturate the node index to the grid and flag it
   always_comb begin
      logic [STR_W-1:0] sat;
      sat       = '0;
      c2_oor_in = 1'b0;
      if (c1_node_ff[BASE_W-1]) begin
         sat       = '0;
         c2_oor_in = 1'b1;
      end else if (c1_node_ff >= $signed({{(BASE_W-STR_W){1'b0}}, total_sel})) begin
         sat       = total_sel - STR_W'(1);
         c2_oor_in = 1'b1;
      end else begin
         sat = c1_node_ff[STR_W-1:0];
      end
      c2_idx_in = sgtw_pkg::NODE_INDEX_W'(sat);
      c2_w_in   = sgtw_pkg::WPROD_W'(c1_w_ff) * sgtw_pkg::WPROD_W'(c1_f2_ff);
   end

   // round half up from Q1.48 to Q1.16
   assign w_round = c2_w_ff + sgtw_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff    <= 1'b0;
         c2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c1_vld_ff    <= ser_vld_ff;
         c2_vld_ff    <= c1_vld_ff;
         rsp_valid_ff <= c2_vld_ff;
      end
      c1_node_ff        <= c1_node_in;
      c1_w_ff           <= c1_w_in;
      c1_f2_ff          <= c1_f2_in;
      c1_corner_ff      <= ser_cnt_ff;
      c2_idx_ff         <= c2_idx_in;
      c2_oor_ff         <= c2_oor_in;
      c2_w_ff           <= c2_w_in;
      c2_corner_ff      <= c1_corner_ff;
      rsp_node_index_ff <= c2_idx_ff;
      rsp_weight_ff     <= w_round[sgtw_pkg::WPROD_W-1:32];
      rsp_corner_ff     <= c2_corner_ff;
      rsp_oor_ff        <= c2_oor_ff;
      rsp_last_ff       <= (c2_corner_ff == sgtw_pkg::LAST_CORNER);
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_node_index       = rsp_node_index_ff;
   assign rsp_weight           = rsp_weight_ff;
   assign rsp_corner_number    = rsp_corner_ff;
   assign rsp_out_of_range     = rsp_oor_ff;
   assign rsp_last_of_particle = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a particle's corners leave back to back with no gap
   `SGTW_ASSERT_NEXT(a_burst_no_gap, clock, reset, rsp_valid && (rsp_corner_number != sgtw_pkg::LAST_CORNER), rsp_valid && (rsp_corner_number == $past(rsp_corner_number) + 3'd1), "corner burst broken")
   // the marker sits on the eighth corner only
   `SGTW_ASSERT_NOW(a_last_marker, clock, reset, rsp_valid, rsp_last_of_particle == (rsp_corner_number == sgtw_pkg::LAST_CORNER), "last marker misplaced")
   // a trilinear weight never exceeds one
   `SGTW_ASSERT_NOW(a_weight_range, clock, reset, rsp_valid, rsp_weight <= sgtw_pkg::ONE_Q16, "weight above one")

endmodule
